### hdl/csv_byte_tokenizer_defines.svh
// Assertion macros shared by the CSV tokenizer RTL.
`ifndef CSV_BYTE_TOKENIZER_DEFINES_SVH
`define CSV_BYTE_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define CBT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csv tokenizer check failed");
// Check a property on every rising edge once the reset edge has passed.
`define CBT_ASSERT_POST_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> (prop)) \
        else $error("csv tokenizer state check failed");
`else
`define CBT_ASSERT(lbl, clk, rst_n, prop)
`define CBT_ASSERT_POST_RST(lbl, clk, rst_n, prop)
`endif

`endif

### hdl/cbt_pkg.sv
// Package: types, codes and limits of the CSV byte tokenizer.
`timescale 1ns / 1ps

package cbt_pkg;

    localparam int unsigned FIELD_W = 8;
    localparam int unsigned RECORD_W = 16;

    localparam logic [FIELD_W-1:0] FIELD_COUNT_MAX = 8'd255;
    localparam logic [RECORD_W-1:0] RECORD_COUNT_MAX = 16'd65535;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_SEPARATOR  = 1'b0,
        REG_HAS_HEADER = 1'b1
    } t_reg_index;

    // Input kind
    typedef enum logic [0:0] {
        KIND_DATA = 1'b0,
        KIND_EOS  = 1'b1
    } t_kind;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_DATA   = 3'd1,
        ACT_FIELD  = 3'd2,
        ACT_RECORD = 3'd3,
        ACT_ERROR  = 3'd4
    } t_action;

    // Tokenizer state carried from word to word
    typedef struct packed {
        logic                in_quotes;
        logic                quote_pending;
        logic                after_line_break;
        logic                need_separator;
        logic                field_nonempty;
        logic [FIELD_W-1:0]  field_counter;
        logic [RECORD_W-1:0] record_counter;
    } t_state;

    // One result word
    typedef struct packed {
        t_action             action;
        logic [7:0]          out_byte;
        logic [FIELD_W-1:0]  field_index;
        logic [RECORD_W-1:0] record_index;
        logic                is_header;
    } t_result;

endpackage

### hdl/cbt_step.sv
// Next-state and result logic of the tokenizer for one input word.
`timescale 1ns / 1ps

module cbt_step (
    input  cbt_pkg::t_state  i_state,
    input  cbt_pkg::t_kind   i_kind,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_separator,
    input  logic             i_has_header,
    output cbt_pkg::t_state  o_state,
    output cbt_pkg::t_result o_result
);
    import cbt_pkg::*;

    logic   quote_close;
    logic   is_break;
    logic   is_quote;
    logic   eos_close;
    t_state s_mid;
    t_state s_rec;
    logic   rec_header;

    // Record-close variant of the state and header flag
    always_comb begin
        rec_header = i_has_header && (i_state.record_counter == '0);
        s_rec = i_state;
        s_rec.field_nonempty = 1'b0;
        s_rec.after_line_break = 1'b1;
        s_rec.field_counter = '0;
        if (i_state.record_counter < RECORD_COUNT_MAX) begin
            s_rec.record_counter = i_state.record_counter + 16'd1;
        end
    end

    always_comb begin
        is_quote = (i_byte == CH_QUOTE);
        is_break = (i_byte == CH_LF) || (i_byte == CH_CR);
        quote_close = i_state.in_quotes && i_state.quote_pending && !is_quote;
        eos_close = !i_state.after_line_break &&
                    ((i_state.record_counter != '0) || i_state.field_nonempty);

        // Leave the quoted area when a pending quote is not doubled
        s_mid = i_state;
        if (quote_close) begin
            s_mid.in_quotes = 1'b0;
            s_mid.quote_pending = 1'b0;
            s_mid.need_separator = 1'b1;
        end

        o_state = s_mid;
        o_result.action = ACT_NONE;
        o_result.out_byte = '0;
        o_result.field_index = i_state.field_counter;
        o_result.record_index = i_state.record_counter;
        o_result.is_header = 1'b0;

        if (i_kind == KIND_EOS) begin
            // Close a trailing record, then drop quoting state
            if (eos_close) begin
                o_state = s_rec;
                o_result.action = ACT_RECORD;
                o_result.is_header = rec_header;
            end else begin
                o_state = i_state;
            end
            o_state.in_quotes = 1'b0;
            o_state.quote_pending = 1'b0;
            o_state.need_separator = 1'b0;
        end else if (s_mid.in_quotes) begin
            // Inside quotes: hold a quote as pending, append anything else
            if (is_quote && !s_mid.quote_pending) begin
                o_state.quote_pending = 1'b1;
            end else begin
                o_state.quote_pending = 1'b0;
                o_state.field_nonempty = 1'b1;
                o_result.action = ACT_DATA;
                o_result.out_byte = i_byte;
            end
        end else begin
            if (!is_break) begin
                o_state.after_line_break = 1'b0;
            end
            if (is_quote) begin
                if (s_mid.need_separator) begin
                    o_result.action = ACT_ERROR;
                end else begin
                    o_state.in_quotes = 1'b1;
                    o_state.quote_pending = 1'b0;
                end
            end else if (i_byte == i_separator) begin
                o_result.action = ACT_FIELD;
                if (s_mid.field_counter < FIELD_COUNT_MAX) begin
                    o_state.field_counter = s_mid.field_counter + 8'd1;
                end
                o_state.field_nonempty = 1'b0;
                o_state.need_separator = 1'b0;
            end else if (is_break) begin
                // Only the first of a run of line breaks closes a record
                if (!s_mid.after_line_break) begin
                    o_state = s_rec;
                    o_state.in_quotes = s_mid.in_quotes;
                    o_state.quote_pending = s_mid.quote_pending;
                    o_result.action = ACT_RECORD;
                    o_result.is_header = rec_header;
                end
                o_state.need_separator = 1'b0;
            end else if (s_mid.need_separator) begin
                o_result.action = ACT_ERROR;
            end else begin
                o_state.field_nonempty = 1'b1;
                o_result.action = ACT_DATA;
                o_result.out_byte = i_byte;
            end
        end
    end

endmodule

### hdl/csv_byte_tokenizer.sv
// Top level of the CSV byte tokenizer: registers, handshakes and checks.
//
// channel  | side   | ports            | payload
// ---------+--------+------------------+---------------------------------------------------
// input    | slave  | *_s_axis_*       | tuser: kind; tdata: data_byte
// result   | master | *_m_axis_*       | tuser: action, is_header; tdata: byte, field, record
// config   | write  | *_cfg_*          | i_cfg_index, i_cfg_data
//
// One word in, one result out; a new word is taken in every cycle while the
// result side keeps up. Each word passes through the input register, then the
// result register fed by the tokenizer step logic, which also updates state.
// A stall on the result side backs up through the input register only.
// Synchronous active-low reset clears state and valid flags and resets configuration.
`timescale 1ns / 1ps
`include "csv_byte_tokenizer_defines.svh"

module csv_byte_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind
    // result words
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] out_byte, [15:8] field_index,
                                          // [31:16] record_index
    output logic [3:0]  o_m_axis_tuser,   // [2:0] action, [3] is_header
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  cbt_pkg::t_reg_index i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import cbt_pkg::*;

    logic       r_in_valid;
    t_kind      r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    logic [7:0] r_separator;
    logic       r_has_header;

    t_state     n_state;
    t_result    n_out;
    logic       adv;
    logic       in_acc;

    // Advance when the result register is free or being emptied
    assign adv = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    cbt_step u_step (
        .i_state      (r_state),
        .i_kind       (r_in_kind),
        .i_byte       (r_in_byte),
        .i_separator  (r_separator),
        .i_has_header (r_has_header),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    // Control state, tokenizer state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state <= '0;
            r_separator <= SEPARATOR_RESET;
            r_has_header <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_SEPARATOR:  r_separator <= i_cfg_data;
                    REG_HAS_HEADER: r_has_header <= i_cfg_data[0];
                    default:        r_separator <= r_separator;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_kind <= t_kind'(i_s_axis_tuser[0]);
            r_in_byte <= i_s_axis_tdata;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {r_out.record_index, r_out.field_index, r_out.out_byte};
    assign o_m_axis_tuser = {r_out.is_header, r_out.action};

    // Checks
    `CBT_ASSERT(a_byte_only_on_data, i_clk, i_rst_n,
        r_out_valid |-> ((r_out.action == ACT_DATA) || (r_out.out_byte == 8'd0)))
    `CBT_ASSERT(a_header_only_on_record, i_clk, i_rst_n,
        (r_out_valid && r_out.is_header) |-> (r_out.action == ACT_RECORD))
    `CBT_ASSERT(a_record_count_monotonic, i_clk, i_rst_n,
        adv |=> (r_state.record_counter >= $past(r_state.record_counter)))
    `CBT_ASSERT_POST_RST(a_quote_flags_consistent, i_clk, i_rst_n,
        !(r_state.in_quotes && r_state.need_separator) &&
        (!r_state.quote_pending || r_state.in_quotes))

endmodule

### sim/csv_byte_tokenizer_tb.sv
// Self-checking testbench of the CSV byte tokenizer: random CSV streams, predicted results.
`timescale 1ns / 1ps

module csv_byte_tokenizer_tb;

    import cbt_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_WORDS = 120;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_word;

    // DUT connections; the ones driven here are all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    t_reg_index  cfg_index = REG_SEPARATOR;
    logic [7:0]  cfg_data = 8'h00;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire  [3:0]  m_tuser;
    wire         cfg_ready;

    // Stimulus and expectation stores
    t_word       word_q[$];
    t_result     expected_q[$];
    int unsigned n_pushed = 0;
    int unsigned n_taken = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;

    // Idling control, set per phase
    int unsigned idle_pct = 0;
    bit          calm = 1'b0;
    bit          want_hold = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned stall_cnt = 0;

    // Tokenizer shadow state and configuration
    logic        sh_in_quotes = 1'b0;
    logic        sh_quote_pend = 1'b0;
    logic        sh_after_break = 1'b0;
    logic        sh_need_sep = 1'b0;
    logic        sh_field_full = 1'b0;
    logic [7:0]  sh_field_cnt = 8'd0;
    logic [15:0] sh_record_cnt = 16'd0;
    logic [7:0]  sep_val = SEPARATOR_RESET;
    logic        header_en = 1'b0;

    csv_byte_tokenizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Build a result word from the current counters
    function automatic t_result token_at(t_action act, logic [7:0] ob, logic hdr);
        t_result r;
        r.action = act;
        r.out_byte = ob;
        r.field_index = sh_field_cnt;
        r.record_index = sh_record_cnt;
        r.is_header = hdr;
        return r;
    endfunction

    // Close the current record, advance the saturating record counter, clear the field counter
    function automatic t_result close_record_token();
        t_result r;
        r = token_at(ACT_RECORD, 8'h00, header_en && (sh_record_cnt == 16'd0));
        sh_field_full = 1'b0;
        sh_after_break = 1'b1;
        if (sh_record_cnt != RECORD_COUNT_MAX)
            sh_record_cnt = sh_record_cnt + 16'd1;
        sh_field_cnt = 8'd0;
        return r;
    endfunction

    // Predict the action for one accepted input word
    function automatic t_result tokenize(t_kind kind, logic [7:0] b);
        t_result r;
        logic    is_break;
        if (kind == KIND_EOS) begin
            if (!sh_after_break && (sh_record_cnt != 16'd0 || sh_field_full))
                r = close_record_token();
            else
                r = token_at(ACT_NONE, 8'h00, 1'b0);
            sh_in_quotes = 1'b0;
            sh_quote_pend = 1'b0;
            sh_need_sep = 1'b0;
            return r;
        end
        // a pending quote followed by anything else ends the quoted area
        if (sh_in_quotes && sh_quote_pend && b != CH_QUOTE) begin
            sh_in_quotes = 1'b0;
            sh_quote_pend = 1'b0;
            sh_need_sep = 1'b1;
        end
        if (sh_in_quotes) begin
            if (b == CH_QUOTE && !sh_quote_pend) begin
                sh_quote_pend = 1'b1;
                return token_at(ACT_NONE, 8'h00, 1'b0);
            end
            sh_quote_pend = 1'b0;
            sh_field_full = 1'b1;
            return token_at(ACT_DATA, b, 1'b0);
        end
        is_break = (b == CH_LF) || (b == CH_CR);
        if (sh_after_break && !is_break)
            sh_after_break = 1'b0;
        // quote meaning wins over the separator
        if (b == CH_QUOTE) begin
            if (sh_need_sep)
                return token_at(ACT_ERROR, 8'h00, 1'b0);
            sh_in_quotes = 1'b1;
            sh_quote_pend = 1'b0;
            return token_at(ACT_NONE, 8'h00, 1'b0);
        end
        // separator meaning wins over CR and LF
        if (b == sep_val) begin
            r = token_at(ACT_FIELD, 8'h00, 1'b0);
            if (sh_field_cnt != FIELD_COUNT_MAX)
                sh_field_cnt = sh_field_cnt + 8'd1;
            sh_field_full = 1'b0;
            sh_need_sep = 1'b0;
            return r;
        end
        if (is_break) begin
            sh_need_sep = 1'b0;
            if (!sh_after_break)
                return close_record_token();
            return token_at(ACT_NONE, 8'h00, 1'b0);
        end
        if (sh_need_sep)
            return token_at(ACT_ERROR, 8'h00, 1'b0);
        sh_field_full = 1'b1;
        return token_at(ACT_DATA, b, 1'b0);
    endfunction

    function automatic void note_error(string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Sender: present words from the queue, predict each accepted word
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.insert(expected_q.size(), tokenize(t_kind'(s_tuser), s_tdata));
                n_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(1, 17) - 1;
                    s_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    w = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= w.kind;
                    s_tdata <= w.value;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (expected_q.size() == 0) begin
                    note_error($sformatf("result word with nothing expected: tuser %h tdata %h",
                                         m_tuser, m_tdata));
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser[2:0] !== want.action || m_tuser[3] !== want.is_header ||
                        m_tdata[7:0] !== want.out_byte ||
                        m_tdata[15:8] !== want.field_index ||
                        m_tdata[31:16] !== want.record_index)
                        note_error($sformatf({"exp/got action %0d/%0d byte %h/%h field %0d/%0d",
                                              " record %0d/%0d header %0b/%0b"},
                                             want.action, m_tuser[2:0],
                                             want.out_byte, m_tdata[7:0],
                                             want.field_index, m_tdata[15:8],
                                             want.record_index, m_tdata[31:16],
                                             want.is_header, m_tuser[3]));
                end
            end
            // one long hold-off so that the block backs up into its input
            if (want_hold && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                recv_gap = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_word(t_kind kind, logic [7:0] value);
        t_word w;
        w.kind = kind;
        w.value = value;
        word_q.insert(word_q.size(), w);
        n_pushed++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(KIND_DATA, s[i]);
    endtask

    // Any byte other than quote, separator and line breaks
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == sep_val || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // Random byte leaning towards the bytes with a meaning
    function automatic logic [7:0] keen_byte();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return sep_val;
            2: return CH_CR;
            3: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One record with random fields, quoting and line ending; some fields are broken
    task automatic push_record();
        int unsigned nf;
        int unsigned len;
        logic [7:0]  b;
        nf = $urandom_range(1, 5);
        for (int f = 0; f < nf; f++) begin
            if (f > 0)
                push_word(KIND_DATA, sep_val);
            len = $urandom_range(0, 6);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    for (int i = 0; i < len; i++)
                        push_word(KIND_DATA, plain_byte());
                end
                6, 7, 8: begin
                    push_word(KIND_DATA, CH_QUOTE);
                    for (int i = 0; i < len; i++) begin
                        b = keen_byte();
                        push_word(KIND_DATA, b);
                        if (b == CH_QUOTE)
                            push_word(KIND_DATA, CH_QUOTE);
                    end
                    push_word(KIND_DATA, CH_QUOTE);
                end
                default: begin
                    // broken field: stray bytes of any kind
                    for (int i = 0; i <= len; i++)
                        push_word(KIND_DATA, keen_byte());
                end
            endcase
        end
        case ($urandom_range(0, 7))
            0: push_word(KIND_DATA, CH_CR);
            1: begin
                push_word(KIND_DATA, CH_CR);
                push_word(KIND_DATA, CH_LF);
            end
            2: begin
                push_word(KIND_DATA, CH_LF);
                push_word(KIND_DATA, CH_LF);
            end
            3: push_word(KIND_EOS, 8'($urandom_range(0, 255)));
            4: begin
                push_word(KIND_DATA, CH_CR);
                push_word(KIND_DATA, CH_CR);
                push_word(KIND_DATA, CH_LF);
            end
            default: push_word(KIND_DATA, CH_LF);
        endcase
    endtask

    // Noise burst: random bytes with the odd end of stream
    task automatic push_noise();
        int unsigned len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                push_word(KIND_EOS, 8'($urandom_range(0, 255)));
            else
                push_word(KIND_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(t_reg_index idx, logic [7:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SEPARATOR)
            sep_val = value;
        else
            header_en = value[0];
    endtask

    // Wait until every pushed word has gone in and its result has come out
    task automatic drain();
        do
            @(posedge i_clk);
        while (n_taken != n_pushed || n_checked != n_taken);
    endtask

    initial begin
        logic [7:0]  sep_list[8];
        int unsigned start;
        sep_list = '{8'd44, 8'd0, 8'd255, CH_QUOTE, CH_CR, CH_LF, 8'h09, 8'h00};
        sep_list[7] = 8'($urandom_range(0, 255));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // end of stream on an empty stream closes no record
        push_word(KIND_EOS, 8'hFF);
        drain();
        write_reg(REG_HAS_HEADER, 8'd1);

        // doubled quote, closing quote, text after it, header record, repeated break
        push_text("\"a\"\"b\",");
        push_text("\"x\"z\"\r\n");
        // quote opening mid-field, line break closing the quote
        push_text("q\",\"\n");
        push_word(KIND_DATA, 8'h00);
        push_word(KIND_DATA, 8'hFF);
        // trailing record closed by end of stream, then no further record
        push_word(KIND_EOS, 8'h00);
        push_word(KIND_EOS, 8'h55);

        // random phases over a spread of separators
        for (int p = 0; p < 8; p++) begin
            drain();
            write_reg(REG_SEPARATOR, sep_list[p]);
            write_reg(REG_HAS_HEADER, 8'($urandom_range(0, 1)));
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 12;
                default: idle_pct = 40;
            endcase
            start = n_pushed;
            while (n_pushed - start < PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0)
                    push_noise();
                else
                    push_record();
            end
            if (p == 1)
                want_hold = 1'b1;
        end

        // saturate the field counter
        drain();
        calm = 1'b1;
        write_reg(REG_SEPARATOR, SEPARATOR_RESET);
        for (int i = 0; i < 270; i++)
            push_word(KIND_DATA, SEPARATOR_RESET);
        push_word(KIND_DATA, CH_LF);

        // a little more random traffic with no idling
        drain();
        start = n_pushed;
        while (n_pushed - start < PHASE_WORDS)
            push_record();

        drain();
        repeat (6) @(posedge i_clk);
        if (expected_q.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_q.size()));
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/cbt_pkg.sv
hdl/cbt_step.sv
hdl/csv_byte_tokenizer.sv
sim/csv_byte_tokenizer_tb.sv
